### sv/accel_shake_classifier_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accelerometer shake classifier.
// Every macro expects clk and rst to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef ACCEL_SHAKE_CLASSIFIER_CORE_ASSERT_SVH
`define ACCEL_SHAKE_CLASSIFIER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shake classifier check failed");

// The consequent must hold in the cycle after the antecedent.
`define ACS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shake classifier check failed");

`endif

### sv/acs_pkg.sv
// ----------------------------------------------------------------------------
// Shake classifier package
// Shared widths, configuration record, register map and result codes.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned OPND_W = 28;
  localparam int unsigned PROD_W = 56;
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned CNT_W  = 3;

  localparam logic [CNT_W-1:0] SHORT_DIGITS = 3'd4;
  localparam logic [CNT_W-1:0] LONG_DIGITS  = 3'd7;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] REG_COOLDOWN = 3'd0;
  localparam logic [2:0] REG_AXIS     = 3'd1;
  localparam logic [2:0] REG_ONE_G    = 3'd2;
  localparam logic [2:0] REG_LIGHT    = 3'd3;
  localparam logic [2:0] REG_MEDIUM   = 3'd4;
  localparam logic [2:0] REG_HEAVY    = 3'd5;

  localparam logic [15:0] COOLDOWN_RST = 16'd3000;
  localparam logic [15:0] AXIS_RST     = 16'd35000;
  localparam logic [14:0] ONE_G_RST    = 15'd16384;
  localparam logic [11:0] LIGHT_RST    = 12'd512;
  localparam logic [11:0] MEDIUM_RST   = 12'd922;
  localparam logic [11:0] HEAVY_RST    = 12'd1331;

  localparam logic [1:0] LEVEL_NONE   = 2'd0;
  localparam logic [1:0] LEVEL_LIGHT  = 2'd1;
  localparam logic [1:0] LEVEL_MEDIUM = 2'd2;
  localparam logic [1:0] LEVEL_HEAVY  = 2'd3;

  typedef struct packed {
    logic [15:0] cooldown_ms;
    logic [15:0] axis_limit;
    logic [14:0] one_g_counts;
    logic [11:0] light_threshold;
    logic [11:0] medium_threshold;
    logic [11:0] heavy_threshold;
  } cfg_t;

endpackage

### sv/accel_shake_classifier_core.sv
// A suppressed or invalid sample or an over-limit axis goes from S_CHECK
// straight to S_DONE; any other sample is squared and compared first.
// One sample is in flight at a time, so a new sample is taken only once the
// last result is on the output; the sum of squares takes three passes of the
// 4-bit digit multiplier. After reset or a register write the next sample
// first refreshes the squared bounds. Synchronous reset.
// ----------------------------------------------------------------------------
// Accelerometer shake classifier
// Classifies the deviation of each sample's magnitude from 1 g against three
// thresholds and suppresses detections inside a cooldown window.
// ----------------------------------------------------------------------------
module accel_shake_classifier_core (
  input  logic                        clk,
  input  logic                        rst,
  // timestamp_ms[31:0], accel_x[47:32], accel_y[63:48], accel_z[79:64]
  input  logic [79:0]                 s_tdata,
  // sample_ok[0]
  input  logic                        s_tuser,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // shake_level[1:0], zeros above
  output logic [7:0]                  m_tdata,
  // in_cooldown[0]
  output logic                        m_tuser,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acs_pkg::ADDR_W-1:0]  paddr,
  input  logic [acs_pkg::DATA_W-1:0]  pwdata,
  output logic [acs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_BND, S_BNDW, S_SQ, S_SQW, S_CMP, S_DONE
  } state_t;

  state_t state;

  acs_pkg::cfg_t cfg;
  logic          cfg_wr;

  logic [31:0] now_r;
  logic        ok_r;
  logic [15:0] mag [3];
  logic [31:0] last_shake;
  logic        dirty;
  logic [1:0]  k;
  logic [1:0]  op;
  logic [1:0]  j;
  logic [27:0] tmp;
  logic [55:0] hi_sq [3];
  logic [55:0] lo_sq [3];
  logic [1:0]  level;
  logic        cool;
  logic [1:0]  out_level;
  logic        out_cool;

  logic                        mul_start;
  logic                        mul_accum;
  logic [acs_pkg::OPND_W-1:0]  mul_mcand;
  logic [acs_pkg::OPND_W-1:0]  mul_mplier;
  logic [acs_pkg::CNT_W-1:0]   mul_ndig;
  logic                        mul_done;
  logic [acs_pkg::PROD_W-1:0]  mul_product;

  logic [11:0] thr;
  logic [12:0] hi_fac;
  logic [10:0] lo_fac;
  logic [31:0] elapsed;
  logic        in_window;
  logic        over_axis;
  logic [55:0] s_scaled;
  logic        exceeds;
  logic        in_acc;
  logic        out_free;

  acs_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  acs_digit_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .accum   (mul_accum),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .ndig    (mul_ndig),
    .done    (mul_done),
    .product (mul_product)
  );

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {6'd0, out_level};
  assign m_tuser  = out_cool;

  always_comb begin
    unique case (k)
      2'd0:    thr = cfg.heavy_threshold;
      2'd1:    thr = cfg.medium_threshold;
      default: thr = cfg.light_threshold;
    endcase
  end

  assign hi_fac = 13'd1024 + 13'(thr);
  assign lo_fac = (thr < 12'd1024) ? (11'd1024 - 11'(thr[9:0])) : 11'd0;

  assign elapsed   = now_r - last_shake;
  assign in_window = elapsed < {16'd0, cfg.cooldown_ms};
  assign over_axis = (mag[0] > cfg.axis_limit) || (mag[1] > cfg.axis_limit) ||
                     (mag[2] > cfg.axis_limit);

  assign s_scaled = {4'd0, mul_product[31:0], 20'd0};
  assign exceeds  = (s_scaled > hi_sq[k]) || (s_scaled < lo_sq[k]);

  assign mul_start = (state == S_BND) || (state == S_SQ);

  always_comb begin
    mul_mcand  = '0;
    mul_mplier = '0;
    mul_ndig   = acs_pkg::SHORT_DIGITS;
    mul_accum  = 1'b0;
    if (state == S_SQ) begin
      mul_mcand  = 28'(mag[j]);
      mul_mplier = 28'(mag[j]);
      mul_accum  = (j != 2'd0);
    end else begin
      unique case (op)
        2'd0: begin
          mul_mcand  = 28'(cfg.one_g_counts);
          mul_mplier = 28'(hi_fac);
        end
        2'd2: begin
          mul_mcand  = 28'(cfg.one_g_counts);
          mul_mplier = 28'(lo_fac);
        end
        default: begin
          mul_mcand  = tmp;
          mul_mplier = tmp;
          mul_ndig   = acs_pkg::LONG_DIGITS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      m_tvalid   <= 1'b0;
      last_shake <= '0;
      dirty      <= 1'b1;
      k          <= '0;
      op         <= '0;
      j          <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_wr) begin
        dirty <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            now_r  <= s_tdata[31:0];
            ok_r   <= s_tuser;
            mag[0] <= s_tdata[47] ? 16'(~s_tdata[47:32] + 16'd1) : s_tdata[47:32];
            mag[1] <= s_tdata[63] ? 16'(~s_tdata[63:48] + 16'd1) : s_tdata[63:48];
            mag[2] <= s_tdata[79] ? 16'(~s_tdata[79:64] + 16'd1) : s_tdata[79:64];
            state  <= S_CHECK;
          end
        end
        S_CHECK: begin
          level <= acs_pkg::LEVEL_NONE;
          cool  <= 1'b0;
          k     <= '0;
          op    <= '0;
          j     <= '0;
          priority if (in_window) begin
            cool  <= 1'b1;
            state <= S_DONE;
          end else if (!ok_r) begin
            state <= S_DONE;
          end else if (over_axis) begin
            level <= acs_pkg::LEVEL_HEAVY;
            state <= S_DONE;
          end else if (dirty) begin
            state <= S_BND;
          end else begin
            state <= S_SQ;
          end
        end
        S_BND: begin
          state <= S_BNDW;
        end
        S_BNDW: begin
          if (mul_done) begin
            unique case (op)
              2'd1:    hi_sq[k] <= mul_product;
              2'd3:    lo_sq[k] <= mul_product;
              default: tmp      <= mul_product[27:0];
            endcase
            op <= op + 2'd1;
            if (op == 2'd3) begin
              if (k == 2'd2) begin
                k     <= '0;
                dirty <= 1'b0;
                state <= S_SQ;
              end else begin
                k     <= k + 2'd1;
                state <= S_BND;
              end
            end else begin
              state <= S_BND;
            end
          end
        end
        S_SQ: begin
          state <= S_SQW;
        end
        S_SQW: begin
          if (mul_done) begin
            if (j == 2'd2) begin
              k     <= '0;
              state <= S_CMP;
            end else begin
              j     <= j + 2'd1;
              state <= S_SQ;
            end
          end
        end
        S_CMP: begin
          if (exceeds) begin
            level <= 2'(acs_pkg::LEVEL_HEAVY - k);
            state <= S_DONE;
          end else if (k == 2'd2) begin
            state <= S_DONE;
          end else begin
            k <= k + 2'd1;
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid  <= 1'b1;
            out_level <= level;
            out_cool  <= cool;
            if (level != acs_pkg::LEVEL_NONE) begin
              last_shake <= now_r;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/acs_cfg_regs.sv
// ----------------------------------------------------------------------------
// Shake classifier configuration registers
// Register file behind the peripheral bus port, with read back.
// ----------------------------------------------------------------------------
module acs_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acs_pkg::ADDR_W-1:0]  paddr,
  input  logic [acs_pkg::DATA_W-1:0]  pwdata,
  output logic [acs_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output acs_pkg::cfg_t               cfg,
  output logic                        cfg_wr
);

  logic [2:0] idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_wr = wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cooldown_ms      <= acs_pkg::COOLDOWN_RST;
      cfg.axis_limit       <= acs_pkg::AXIS_RST;
      cfg.one_g_counts     <= acs_pkg::ONE_G_RST;
      cfg.light_threshold  <= acs_pkg::LIGHT_RST;
      cfg.medium_threshold <= acs_pkg::MEDIUM_RST;
      cfg.heavy_threshold  <= acs_pkg::HEAVY_RST;
    end else if (wr_en) begin
      unique case (idx)
        acs_pkg::REG_COOLDOWN: cfg.cooldown_ms      <= pwdata[15:0];
        acs_pkg::REG_AXIS:     cfg.axis_limit       <= pwdata[15:0];
        acs_pkg::REG_ONE_G:    cfg.one_g_counts     <= pwdata[14:0];
        acs_pkg::REG_LIGHT:    cfg.light_threshold  <= pwdata[11:0];
        acs_pkg::REG_MEDIUM:   cfg.medium_threshold <= pwdata[11:0];
        acs_pkg::REG_HEAVY:    cfg.heavy_threshold  <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      acs_pkg::REG_COOLDOWN: prdata = {16'd0, cfg.cooldown_ms};
      acs_pkg::REG_AXIS:     prdata = {16'd0, cfg.axis_limit};
      acs_pkg::REG_ONE_G:    prdata = {17'd0, cfg.one_g_counts};
      acs_pkg::REG_LIGHT:    prdata = {20'd0, cfg.light_threshold};
      acs_pkg::REG_MEDIUM:   prdata = {20'd0, cfg.medium_threshold};
      acs_pkg::REG_HEAVY:    prdata = {20'd0, cfg.heavy_threshold};
      default:               prdata = '0;
    endcase
  end

endmodule

### sv/acs_digit_mul.sv
// ----------------------------------------------------------------------------
// Shake classifier digit-serial multiplier
// Shift-and-add multiplier taking one 4-bit digit of the multiplier per
// cycle, with an option to add the new product to the previous result.
// ----------------------------------------------------------------------------
module acs_digit_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        accum,
  input  logic [acs_pkg::OPND_W-1:0]  mcand,
  input  logic [acs_pkg::OPND_W-1:0]  mplier,
  input  logic [acs_pkg::CNT_W-1:0]   ndig,
  output logic                        done,
  output logic [acs_pkg::PROD_W-1:0]  product
);

  logic [acs_pkg::PROD_W-1:0] mc;
  logic [acs_pkg::OPND_W-1:0] mp;
  logic [acs_pkg::CNT_W-1:0]  cnt;
  logic                       busy;
  logic [acs_pkg::PROD_W-1:0] pp;

  always_comb begin
    pp = '0;
    for (int b = 0; b < acs_pkg::DIG_W; b++) begin
      if (mp[b]) begin
        pp = pp + (mc << b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (cnt == 3'd1);
      if (start) begin
        mc   <= {{(acs_pkg::PROD_W-acs_pkg::OPND_W){1'b0}}, mcand};
        mp   <= mplier;
        cnt  <= ndig;
        busy <= 1'b1;
        if (!accum) begin
          product <= '0;
        end
      end else if (busy) begin
        product <= product + pp;
        mc      <= mc << acs_pkg::DIG_W;
        mp      <= mp >> acs_pkg::DIG_W;
        cnt     <= cnt - 1'b1;
        if (cnt == 3'd1) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

### sv/acs_checker.sv
// ----------------------------------------------------------------------------
// Shake classifier port checker
// Checks result encoding and transaction ordering seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "accel_shake_classifier_core_assert.svh"

module acs_checker (
  input logic                        clk,
  input logic                        rst,
  input logic [79:0]                 s_tdata,
  input logic                        s_tuser,
  input logic                        s_tvalid,
  input logic                        s_tready,
  input logic [7:0]                  m_tdata,
  input logic                        m_tuser,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [acs_pkg::ADDR_W-1:0]  paddr,
  input logic [acs_pkg::DATA_W-1:0]  pwdata,
  input logic [acs_pkg::DATA_W-1:0]  prdata,
  input logic                        pready
);

  // A suppressed sample never reports a shake.
  `ACS_ASSERT_SAME(a_cool_none, m_tvalid && m_tuser, m_tdata[1:0] == acs_pkg::LEVEL_NONE)
  // The block works on one sample at a time.
  `ACS_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
  // No result is presented straight after reset.
  `ACS_ASSERT_SAME(a_reset_empty, $past(rst), !m_tvalid)
  `ACS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind accel_shake_classifier_core acs_checker u_acs_checker (.*);

### dv/accel_shake_classifier_checker.sv
// ----------------------------------------------------------------------------
// Shake classifier checker
// Follows the register port, the sample stream and the result stream. Every
// accepted sample is classified here against the registers as written, and
// the level and cooldown flag are queued. Each result is then compared with
// the oldest queued one. Register reads are compared with the written values.
// ----------------------------------------------------------------------------
module accel_shake_classifier_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [79:0]                 s_tdata,
  input  logic                        s_tuser,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  m_tdata,
  input  logic                        m_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [acs_pkg::ADDR_W-1:0]  paddr,
  input  logic [acs_pkg::DATA_W-1:0]  pwdata,
  input  logic [acs_pkg::DATA_W-1:0]  prdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending_results,
  output int                          results_checked,
  output int                          cooldown_results,
  output int                          shake_results
);
  import acs_pkg::*;

  typedef struct packed {
    logic [1:0] level;
    logic       cooldown;
  } verdict_t;

  cfg_t        settings;
  logic [31:0] last_detection_ms;
  verdict_t    expected_verdicts[$];

  function automatic logic [31:0] register_value(input logic [2:0] idx);
    case (idx)
      REG_COOLDOWN: return {16'd0, settings.cooldown_ms};
      REG_AXIS:     return {16'd0, settings.axis_limit};
      REG_ONE_G:    return {17'd0, settings.one_g_counts};
      REG_LIGHT:    return {20'd0, settings.light_threshold};
      REG_MEDIUM:   return {20'd0, settings.medium_threshold};
      REG_HEAVY:    return {20'd0, settings.heavy_threshold};
      default:      return '0;
    endcase
  endfunction

  function automatic bit deviates_beyond(input longint scaled_sq, input longint thr);
    longint g;
    longint upper;
    longint lower;
    g = longint'(settings.one_g_counts);
    upper = g * (1024 + thr);
    if (scaled_sq > upper * upper) return 1'b1;
    if (thr < 1024) begin
      lower = g * (1024 - thr);
      if (scaled_sq < lower * lower) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic verdict_t classify_sample(input logic [31:0] now, input logic ok,
                                               input logic signed [15:0] x,
                                               input logic signed [15:0] y,
                                               input logic signed [15:0] z);
    verdict_t    v;
    logic [31:0] since;
    longint      ax;
    longint      ay;
    longint      az;
    longint      scaled_sq;
    v.level = LEVEL_NONE;
    v.cooldown = 1'b0;
    since = now - last_detection_ms;
    if (since < {16'd0, settings.cooldown_ms}) begin
      v.cooldown = 1'b1;
      return v;
    end
    if (!ok) return v;
    ax = x;
    ay = y;
    az = z;
    if (ax < 0) ax = -ax;
    if (ay < 0) ay = -ay;
    if (az < 0) az = -az;
    if (ax > longint'(settings.axis_limit) || ay > longint'(settings.axis_limit) ||
        az > longint'(settings.axis_limit)) begin
      v.level = LEVEL_HEAVY;
    end else begin
      scaled_sq = (ax * ax + ay * ay + az * az) * 1048576;
      if (deviates_beyond(scaled_sq, longint'(settings.heavy_threshold)))
        v.level = LEVEL_HEAVY;
      else if (deviates_beyond(scaled_sq, longint'(settings.medium_threshold)))
        v.level = LEVEL_MEDIUM;
      else if (deviates_beyond(scaled_sq, longint'(settings.light_threshold)))
        v.level = LEVEL_LIGHT;
    end
    if (v.level != LEVEL_NONE) last_detection_ms = now;
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      settings.cooldown_ms = COOLDOWN_RST;
      settings.axis_limit = AXIS_RST;
      settings.one_g_counts = ONE_G_RST;
      settings.light_threshold = LIGHT_RST;
      settings.medium_threshold = MEDIUM_RST;
      settings.heavy_threshold = HEAVY_RST;
      last_detection_ms = '0;
      expected_verdicts.delete();
      fail_count = 0;
      pending_results = 0;
      results_checked = 0;
      cooldown_results = 0;
      shake_results = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[ADDR_W-1:2])
            REG_COOLDOWN: settings.cooldown_ms = pwdata[15:0];
            REG_AXIS:     settings.axis_limit = pwdata[15:0];
            REG_ONE_G:    settings.one_g_counts = pwdata[14:0];
            REG_LIGHT:    settings.light_threshold = pwdata[11:0];
            REG_MEDIUM:   settings.medium_threshold = pwdata[11:0];
            REG_HEAVY:    settings.heavy_threshold = pwdata[11:0];
            default: ;
          endcase
        end else if (prdata !== register_value(paddr[ADDR_W-1:2])) begin
          $display("%0t: register read at 0x%0h expected 0x%0h, got 0x%0h", $time, paddr,
                   register_value(paddr[ADDR_W-1:2]), prdata);
          fail_count++;
        end
      end
      if (s_tvalid && s_tready)
        expected_verdicts.push_back(classify_sample(s_tdata[31:0], s_tuser, s_tdata[47:32],
                                                    s_tdata[63:48], s_tdata[79:64]));
      if (m_tvalid && m_tready) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: result with none expected, got level %0d cooldown %0b", $time,
                   m_tdata, m_tuser);
          fail_count++;
        end else begin
          want = expected_verdicts.pop_front();
          results_checked++;
          if (want.cooldown) cooldown_results++;
          if (want.level != LEVEL_NONE) shake_results++;
          if (m_tdata !== {6'd0, want.level}) begin
            $display("%0t: shake_level expected %0d, got %0d", $time, want.level, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.cooldown) begin
            $display("%0t: in_cooldown expected %0b, got %0b", $time, want.cooldown, m_tuser);
            fail_count++;
          end
        end
      end
      pending_results = expected_verdicts.size();
    end
  end

endmodule

### dv/tb_accel_shake_classifier_core.sv
// ----------------------------------------------------------------------------
// Shake classifier testbench
// Drives directed samples around the cooldown edge, the 1 g bounds and
// timestamp wrap, then random samples under a series of register settings
// with varied pacing on both streams. The checker alongside gives the verdict.
// ----------------------------------------------------------------------------
module tb_accel_shake_classifier_core;
  import acs_pkg::*;

  localparam int ITEMS_PER_PHASE = 150;
  localparam int PHASES          = 9;
  localparam int QUIET_LIMIT     = 2000;

  logic                clk;
  logic                rst = 1'b1;
  logic [79:0]         s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [7:0]          m_tdata;
  logic                m_tuser;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  int fail_count;
  int pending_results;
  int results_checked;
  int cooldown_results;
  int shake_results;

  int          idle_pct = 0;
  int          stall_pct = 0;
  int          samples_sent = 0;
  int          quiet_cycles = 0;
  logic [31:0] clock_ms;
  cfg_t        active;

  accel_shake_classifier_core uut (.*);
  accel_shake_classifier_checker chk (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: %0d cycles without a transaction.", QUIET_LIMIT);
      $display("[accel_shake_classifier_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] to_count(input real v);
    if (v >= 32767.0) return 16'h7FFF;
    if (v <= -32768.0) return 16'h8000;
    return 16'($rtoi(v));
  endfunction

  function automatic logic [15:0] extreme_count();
    case ($urandom_range(5))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return to_count($itor(active.axis_limit));
      4:       return to_count(-$itor(active.axis_limit) - 1.0);
      default: return to_count($itor(active.axis_limit) + 1.0);
    endcase
  endfunction

  task automatic send_sample(input logic [31:0] ts, input logic ok, input int x, input int y,
                             input int z);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {16'(z), 16'(y), 16'(x), ts};
    s_tuser <= ok;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    samples_sent++;
  endtask

  task automatic apb_access(input bit is_write, input logic [2:0] idx, input logic [31:0] value,
                            input int width);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= {idx, 2'b00};
    pwdata <= ($urandom << width) | value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    int          pick;
    int          sgn;
    longint      thr;
    longint      target;
    real         ratio;
    real         gr;
    real         ux;
    real         uy;
    real         uz;
    real         norm;
    logic [15:0] vx;
    logic [15:0] vy;
    logic [15:0] vz;
    logic [15:0] lt;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: cooldown edges, exact 1 g bounds, zero vector and wrap.
    send_sample(32'd0, 1'b1, 0, 0, 0);
    send_sample(32'd2999, 1'b1, 32767, 32767, 32767);
    send_sample(32'd3000, 1'b0, 32767, 0, 0);
    send_sample(32'd3001, 1'b1, 0, 0, 16384);
    send_sample(32'd3002, 1'b1, 24576, 0, 0);
    send_sample(32'd3003, 1'b1, 0, 24577, 0);
    send_sample(32'd6002, 1'b1, -32768, -32768, -32768);
    send_sample(32'd6003, 1'b1, 0, 0, 8192);
    send_sample(32'd6004, 1'b1, 0, 0, -8191);
    send_sample(32'd9004, 1'b1, -32768, 0, 0);
    send_sample(32'd12004, 1'b1, 0, 0, 0);
    send_sample(32'd15004, 1'b1, 32767, -32768, 32767);
    send_sample(32'd18004, 1'b1, 0, 1632, 0);
    send_sample(32'd21004, 1'b1, -1631, 0, 0);
    send_sample(32'd24004, 1'b1, 32767, 32767, 0);
    send_sample(32'hFFFF_FFF0, 1'b1, 0, 0, 0);
    send_sample(32'h0000_0010, 1'b1, 32767, 0, 0);
    send_sample(32'd2984, 1'b0, 0, 0, 0);
    send_sample(32'd2985, 1'b1, 0, 0, 16384);

    clock_ms = 32'd100000;
    for (int p = 0; p < PHASES; p++) begin
      s_tvalid <= 1'b0;
      while (pending_results != 0) @(negedge clk);

      case (p)
        0: active = {COOLDOWN_RST, AXIS_RST, ONE_G_RST, LIGHT_RST, MEDIUM_RST, HEAVY_RST};
        1: active = {16'd0, 16'hFFFF, 15'h7FFF, 12'd0, 12'hFFF, 12'hFFF};
        2: active = {16'hFFFF, 16'd0, 15'd1, 12'hFFF, 12'hFFF, 12'hFFF};
        3: active = {16'd0, 16'd35000, 15'd0, 12'd300, 12'd200, 12'd100};
        4: active = {16'd500, 16'd30000, 15'd16384, 12'd1331, 12'd922, 12'd512};
        default: begin
          lt = 16'($urandom_range(1100));
          active = {16'($urandom_range(4000)), 16'($urandom_range(65535, 16000)),
                    15'($urandom_range(32767, 2000)), lt[11:0],
                    12'(lt + 16'($urandom_range(600))), 12'(lt + 16'($urandom_range(1500)))};
          if (p == PHASES - 1) begin
            active.light_threshold = 12'($urandom);
            active.medium_threshold = 12'($urandom);
            active.heavy_threshold = 12'($urandom);
          end
        end
      endcase
      if (p == 5) clock_ms = 32'hFFFF_F000;

      apb_access(1'b1, REG_COOLDOWN, {16'd0, active.cooldown_ms}, 16);
      apb_access(1'b1, REG_AXIS, {16'd0, active.axis_limit}, 16);
      apb_access(1'b1, REG_ONE_G, {17'd0, active.one_g_counts}, 15);
      apb_access(1'b1, REG_LIGHT, {20'd0, active.light_threshold}, 12);
      apb_access(1'b1, REG_MEDIUM, {20'd0, active.medium_threshold}, 12);
      apb_access(1'b1, REG_HEAVY, {20'd0, active.heavy_threshold}, 12);
      for (int r = int'(REG_COOLDOWN); r <= int'(REG_HEAVY); r++)
        apb_access(1'b0, 3'(r), '0, 0);

      case (p % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 48; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 48; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase

      gr = $itor(active.one_g_counts);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(99) < 3)
          clock_ms = $urandom;
        else
          clock_ms = clock_ms + $urandom_range(2 * int'(active.cooldown_ms) + 16);

        case ($urandom_range(2))
          0:       thr = longint'(active.light_threshold);
          1:       thr = longint'(active.medium_threshold);
          default: thr = longint'(active.heavy_threshold);
        endcase
        sgn = ($urandom_range(1) == 1) ? 1 : -1;
        pick = int'($urandom_range(99));

        if (pick < 70) begin
          // Mostly just either side of a threshold bound, in a random direction.
          if (pick < 50)
            ratio = 1.0 + $itor(sgn) * $itor(thr) / 1024.0
                    + ($itor($urandom_range(400)) - 200.0) / 100000.0;
          else
            ratio = $itor($urandom_range(2200)) / 1000.0;
          ux = $itor($urandom_range(2000)) - 1000.0;
          uy = $itor($urandom_range(2000)) - 1000.0;
          uz = $itor($urandom_range(2000)) - 1000.0;
          norm = $sqrt(ux * ux + uy * uy + uz * uz);
          if (norm == 0.0) begin
            uz = 1.0;
            norm = 1.0;
          end
          vx = to_count(ratio * gr * ux / norm);
          vy = to_count(ratio * gr * uy / norm);
          vz = to_count(ratio * gr * uz / norm);
        end else if (pick < 80) begin
          // A single axis on an integer bound, or one count off it.
          target = (longint'(active.one_g_counts) * (1024 + sgn * thr)) / 1024
                   + int'($urandom_range(2)) - 1;
          if ($urandom_range(1) == 1) target = -target;
          vx = '0;
          vy = '0;
          vz = '0;
          case ($urandom_range(2))
            0:       vx = to_count($itor(target));
            1:       vy = to_count($itor(target));
            default: vz = to_count($itor(target));
          endcase
        end else if (pick < 88) begin
          vx = 16'($urandom);
          vy = 16'($urandom);
          vz = 16'($urandom);
        end else if (pick < 95) begin
          vx = extreme_count();
          vy = extreme_count();
          vz = extreme_count();
        end else begin
          vx = 16'(int'($urandom_range(6)) - 3);
          vy = 16'(int'($urandom_range(6)) - 3);
          vz = 16'(int'($urandom_range(6)) - 3);
        end

        send_sample(clock_ms, $urandom_range(99) >= 8, vx, vy, vz);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (30) @(negedge clk);

    $display("Sent %0d samples across %0d register settings, pacing varied per setting.",
             samples_sent, PHASES);
    $display("Checked %0d results: %0d held off by the cooldown, %0d shakes detected.",
             results_checked, cooldown_results, shake_results);
    if (fail_count == 0) begin
      $display("[accel_shake_classifier_core] OK");
    end else begin
      $display("[accel_shake_classifier_core] ERROR");
    end
    $finish;
  end

endmodule
